/* design/rvx_pkg.sv */
// Shared types and constants for the RV32I instruction execute block.
package rvx_pkg;

    // Major opcodes
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // ALU funct3 codes
    localparam logic [2:0] ALU_ADD  = 3'd0;
    localparam logic [2:0] ALU_SLL  = 3'd1;
    localparam logic [2:0] ALU_SLT  = 3'd2;
    localparam logic [2:0] ALU_SLTU = 3'd3;
    localparam logic [2:0] ALU_XOR  = 3'd4;
    localparam logic [2:0] ALU_SR   = 3'd5;
    localparam logic [2:0] ALU_OR   = 3'd6;
    localparam logic [2:0] ALU_AND  = 3'd7;

    // Branch funct3 codes
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    // Load and store funct3 codes
    localparam logic [2:0] LD_B  = 3'd0;
    localparam logic [2:0] LD_H  = 3'd1;
    localparam logic [2:0] LD_W  = 3'd2;
    localparam logic [2:0] LD_BU = 3'd4;
    localparam logic [2:0] LD_HU = 3'd5;
    localparam logic [2:0] ST_B  = 3'd0;
    localparam logic [2:0] ST_H  = 3'd1;
    localparam logic [2:0] ST_W  = 3'd2;

    // SYSTEM immediates that halt
    localparam logic [11:0] SYS_ECALL  = 12'd0;
    localparam logic [11:0] SYS_EBREAK = 12'd1;

    localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;
    localparam logic [31:0] PC_STEP    = 32'd4;

    // Instruction class found by the decoder
    typedef enum logic [3:0] {
        CL_ALU, CL_LUI, CL_AUIPC, CL_JAL, CL_JALR, CL_BRANCH,
        CL_LOAD, CL_STORE, CL_NOP, CL_HALT, CL_ILLEGAL
    } t_cls;

    // Decoded item passed from the front to the back
    typedef struct packed {
        t_cls        cls;
        logic        is_reg;
        logic        alt;
        logic        wr;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [31:0] imm;
    } t_dec;

    // Result item
    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        halted;
        logic        illegal;
    } t_res;

    // Register file write port
    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } t_rf_wr;

endpackage

/* design/rvx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rvx_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/rvx_fifo.sv */
// Small flip-flop queue used between the block's parts.
module rvx_fifo #(
    parameter int W     = 32,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* design/rvx_decode.sv */
// Front part: classifies an instruction word and builds its immediate.
module rvx_decode import rvx_pkg::*; (
    input  logic [31:0] i_instruction,
    output t_dec        o_dec
);

    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    logic        rd_nz;

    assign opc   = i_instruction[6:0];
    assign f3    = i_instruction[14:12];
    assign f7    = i_instruction[31:25];
    assign rd    = i_instruction[11:7];
    assign rd_nz = (rd != 5'd0);
    assign imm_i = {{20{i_instruction[31]}}, i_instruction[31:20]};
    assign imm_s = {{20{i_instruction[31]}}, i_instruction[31:25], i_instruction[11:7]};
    assign imm_b = {{19{i_instruction[31]}}, i_instruction[31], i_instruction[7],
                    i_instruction[30:25], i_instruction[11:8], 1'b0};
    assign imm_u = i_instruction & UPPER_MASK;
    assign imm_j = {{11{i_instruction[31]}}, i_instruction[31], i_instruction[19:12],
                    i_instruction[20], i_instruction[30:21], 1'b0};

    // Classification
    always_comb begin
        o_dec        = '0;
        o_dec.cls    = CL_ILLEGAL;
        o_dec.rd     = rd;
        o_dec.rs1    = i_instruction[19:15];
        o_dec.rs2    = i_instruction[24:20];
        o_dec.f3     = f3;
        o_dec.imm    = imm_i;
        unique case (opc)
            OP_REG, OP_IMM: begin
                o_dec.cls    = CL_ALU;
                o_dec.is_reg = (opc == OP_REG);
                o_dec.wr     = rd_nz;
                if (f3 == ALU_SR || (f3 == ALU_ADD && opc == OP_REG)) begin
                    o_dec.alt = (f7 == F7_ALT);
                    if (f7 != F7_ALT && f7 != F7_BASE) begin
                        o_dec.wr = 1'b0;
                    end
                end
            end
            OP_LUI: begin
                o_dec.cls = CL_LUI;
                o_dec.imm = imm_u;
                o_dec.wr  = rd_nz;
            end
            OP_AUIPC: begin
                o_dec.cls = CL_AUIPC;
                o_dec.imm = imm_u;
                o_dec.wr  = rd_nz;
            end
            OP_JAL: begin
                o_dec.cls = CL_JAL;
                o_dec.imm = imm_j;
                o_dec.wr  = rd_nz;
            end
            OP_JALR: begin
                o_dec.cls = CL_JALR;
                o_dec.wr  = rd_nz;
            end
            OP_BRANCH: begin
                o_dec.cls = CL_BRANCH;
                o_dec.imm = imm_b;
            end
            OP_LOAD: begin
                if (f3 == LD_B || f3 == LD_H || f3 == LD_W || f3 == LD_BU || f3 == LD_HU) begin
                    o_dec.cls = CL_LOAD;
                    o_dec.wr  = rd_nz;
                end else begin
                    o_dec.cls = CL_NOP;
                end
            end
            OP_STORE: begin
                o_dec.imm = imm_s;
                if (f3 == ST_B || f3 == ST_H || f3 == ST_W) begin
                    o_dec.cls = CL_STORE;
                end else begin
                    o_dec.cls = CL_NOP;
                end
            end
            OP_FENCE: begin
                o_dec.cls = CL_NOP;
            end
            OP_SYSTEM: begin
                if (i_instruction[31:20] == SYS_ECALL || i_instruction[31:20] == SYS_EBREAK) begin
                    o_dec.cls = CL_HALT;
                end else begin
                    o_dec.cls = CL_ILLEGAL;
                end
            end
            default: begin
                o_dec.cls = CL_ILLEGAL;
            end
        endcase
    end

endmodule

/* design/rvx_back.sv */
// Back part: register file, data memory, program counter and execution.
module rvx_back import rvx_pkg::*; #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_pc,
    input  logic        i_q_empty,
    input  t_dec        i_q_head,
    output logic        o_q_pop,
    input  logic        i_res_full,
    output logic        o_res_push,
    output t_res        o_res,
    output logic        o_clearing
);

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int RAW  = AW - 2;
    localparam int ROWS = MEM_BYTES / 4;

    // Clearing pass, state and pipeline registers
    logic            r_clr;
    logic [RAW-1:0]  r_clr_cnt;
    logic [31:0]     r_pc;
    logic            r_halt;
    logic            r_e_valid;
    t_dec            r_e;
    logic            r_fa_v, r_fb_v;
    logic [31:0]     r_fa, r_fb;
    logic            r_w_valid, r_w_wr;
    logic [4:0]      r_w_rd;
    logic [2:0]      r_w_f3;
    logic [AW-1:0]   r_w_addr;
    logic [31:0]     r_w_npc;

    logic            e_load, e_done, w_done, advance;
    logic [4:0]      sel_rs1, sel_rs2;
    logic [31:0]     rf_a_q, rf_b_q, a, b, op2, alu, e_addr, e_npc, e_val, ld_raw, ld_val;
    logic [4:0]      sh;
    logic            take, e_wr, e_ill, e_store;
    t_res            e_res, w_res;
    t_rf_wr          rf_wr;
    logic [AW-1:0]   mem_a;
    logic [2:0]      st_n;
    logic [3:0]      lane_we;
    logic [RAW-1:0]  lane_row [4];
    logic [7:0]      lane_wd [4];
    logic [7:0]      lane_q [4];
    logic [7:0]      ld_byte [4];

    assign o_clearing = r_clr;
    assign e_load  = r_e_valid && !r_halt && (r_e.cls == CL_LOAD);
    assign e_done  = r_e_valid && !r_w_valid && (e_load || !i_res_full);
    assign w_done  = r_w_valid && !i_res_full;
    assign advance = !r_clr && !r_w_valid && (!r_e_valid || e_done);
    assign o_q_pop = advance && !i_q_empty;
    assign sel_rs1 = o_q_pop ? i_q_head.rs1 : r_e.rs1;
    assign sel_rs2 = o_q_pop ? i_q_head.rs2 : r_e.rs2;

    // Operands, with a write from the last edge taking the place of stale read data
    assign a   = r_fa_v ? r_fa : rf_a_q;
    assign b   = r_fb_v ? r_fb : rf_b_q;
    assign op2 = r_e.is_reg ? b : r_e.imm;
    assign sh  = op2[4:0];
    assign e_addr = a + r_e.imm;

    // ALU
    always_comb begin
        case (r_e.f3)
            ALU_ADD:  alu = r_e.alt ? a - op2 : a + op2;
            ALU_SLL:  alu = a << sh;
            ALU_SLT:  alu = {31'd0, $signed(a) < $signed(op2)};
            ALU_SLTU: alu = {31'd0, a < op2};
            ALU_XOR:  alu = a ^ op2;
            ALU_SR:   alu = r_e.alt ? 32'($signed(a) >>> sh) : a >> sh;
            ALU_OR:   alu = a | op2;
            default:  alu = a & op2;
        endcase
    end

    // Branch condition
    always_comb begin
        case (r_e.f3)
            BR_EQ:   take = (a == b);
            BR_NE:   take = (a != b);
            BR_LT:   take = ($signed(a) < $signed(b));
            BR_GE:   take = !($signed(a) < $signed(b));
            BR_LTU:  take = (a < b);
            BR_GEU:  take = (a >= b);
            default: take = 1'b0;
        endcase
    end

    // Execute: next pc, register value and flags of the item in the back stage
    always_comb begin
        e_npc   = r_pc + PC_STEP;
        e_val   = alu;
        e_wr    = r_e.wr;
        e_ill   = 1'b0;
        e_store = 1'b0;
        case (r_e.cls)
            CL_LUI:    e_val = r_e.imm;
            CL_AUIPC:  e_val = r_pc + r_e.imm;
            CL_JAL: begin
                e_val = r_pc + PC_STEP;
                e_npc = r_pc + r_e.imm;
            end
            CL_JALR: begin
                e_val = r_pc + PC_STEP;
                e_npc = {e_addr[31:1], 1'b0};
            end
            CL_BRANCH: begin
                if (take) begin
                    e_npc = r_pc + r_e.imm;
                end
            end
            CL_STORE:  e_store = 1'b1;
            CL_HALT:   e_npc = r_pc;
            CL_ILLEGAL: e_ill = 1'b1;
            default: ;
        endcase
        if (r_halt) begin
            e_npc   = r_pc;
            e_wr    = 1'b0;
            e_ill   = 1'b0;
            e_store = 1'b0;
        end
        e_res.next_pc     = e_npc;
        e_res.reg_written = e_wr;
        e_res.reg_index   = e_wr ? r_e.rd : 5'd0;
        e_res.reg_value   = e_wr ? e_val : 32'd0;
        e_res.halted      = r_halt || (r_e.cls == CL_HALT);
        e_res.illegal     = e_ill;
    end

    // Data memory lanes: byte i of an access lies in lane (addr + i) mod 4
    assign mem_a = r_w_valid ? r_w_addr : e_addr[AW-1:0];
    always_comb begin
        case (r_e.f3)
            ST_B:    st_n = 3'd1;
            ST_H:    st_n = 3'd2;
            default: st_n = 3'd4;
        endcase
        for (int l = 0; l < 4; l++) begin
            logic [1:0] bi;
            bi = 2'(l) - mem_a[1:0];
            lane_row[l] = mem_a[AW-1:2] + RAW'(2'(l) < mem_a[1:0]);
            lane_wd[l]  = 8'(b >> {bi, 3'b000});
            lane_we[l]  = e_done && e_store && ({1'b0, bi} < st_n);
            if (r_clr) begin
                lane_row[l] = r_clr_cnt;
                lane_wd[l]  = 8'd0;
                lane_we[l]  = 1'b1;
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        rvx_ram #(.W(8), .D(ROWS)) u_lane (
            .i_clk   (i_clk),
            .i_we    (lane_we[l]),
            .i_waddr (lane_row[l]),
            .i_wdata (lane_wd[l]),
            .i_raddr (lane_row[l]),
            .o_rdata (lane_q[l])
        );
    end

    // Load data assembly and extension
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ld_byte[i] = lane_q[2'(r_w_addr[1:0] + 2'(i))];
        end
        ld_raw = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
        case (r_w_f3)
            LD_B:    ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
            LD_H:    ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
            LD_BU:   ld_val = {24'd0, ld_raw[7:0]};
            LD_HU:   ld_val = {16'd0, ld_raw[15:0]};
            default: ld_val = ld_raw;
        endcase
        w_res.next_pc     = r_w_npc;
        w_res.reg_written = r_w_wr;
        w_res.reg_index   = r_w_wr ? r_w_rd : 5'd0;
        w_res.reg_value   = r_w_wr ? ld_val : 32'd0;
        w_res.halted      = 1'b0;
        w_res.illegal     = 1'b0;
    end

    // Result push and register file write
    assign o_res_push = w_done || (e_done && !e_load);
    assign o_res      = w_done ? w_res : e_res;
    always_comb begin
        rf_wr = '0;
        if (r_clr) begin
            rf_wr.en  = 1'b1;
            rf_wr.idx = r_clr_cnt[4:0];
        end else if (w_done) begin
            rf_wr.en   = r_w_wr;
            rf_wr.idx  = r_w_rd;
            rf_wr.data = ld_val;
        end else if (e_done && !e_load) begin
            rf_wr.en   = e_wr;
            rf_wr.idx  = r_e.rd;
            rf_wr.data = e_val;
        end
    end

    rvx_ram #(.W(32), .D(32)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_wr.en),
        .i_waddr (rf_wr.idx),
        .i_wdata (rf_wr.data),
        .i_raddr (sel_rs1),
        .o_rdata (rf_a_q)
    );

    rvx_ram #(.W(32), .D(32)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_wr.en),
        .i_waddr (rf_wr.idx),
        .i_wdata (rf_wr.data),
        .i_raddr (sel_rs2),
        .o_rdata (rf_b_q)
    );

    // Operand bypass and load stage payload
    always_ff @(posedge i_clk) begin
        r_fa_v <= rf_wr.en && (rf_wr.idx == sel_rs1);
        r_fb_v <= rf_wr.en && (rf_wr.idx == sel_rs2);
        r_fa   <= rf_wr.data;
        r_fb   <= rf_wr.data;
        if (o_q_pop) begin
            r_e <= i_q_head;
        end
        if (e_done && e_load) begin
            r_w_wr   <= r_e.wr;
            r_w_rd   <= r_e.rd;
            r_w_f3   <= r_e.f3;
            r_w_addr <= e_addr[AW-1:0];
            r_w_npc  <= e_npc;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
            r_pc      <= '0;
            r_halt    <= 1'b0;
            r_e_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == RAW'(ROWS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (o_q_pop) begin
                r_e_valid <= 1'b1;
            end else if (e_done) begin
                r_e_valid <= 1'b0;
            end
            if (e_done && e_load) begin
                r_w_valid <= 1'b1;
            end else if (w_done) begin
                r_w_valid <= 1'b0;
            end
            if (e_done && !r_halt && r_e.cls == CL_HALT) begin
                r_halt <= 1'b1;
            end
            if (i_cfg_we) begin
                r_pc <= i_cfg_pc;
            end else if (e_done && !r_halt) begin
                r_pc <= e_npc;
            end
        end
    end

endmodule

/* design/rv32i_instruction_execute.sv */
// Top level of the RV32I instruction execute block.
//
// Instruction words enter through a queue-style port: an item is taken at a
// clock edge where push is high and full is low. Results leave the same way:
// the oldest result is on the o_ ports while empty is low and is taken at an
// edge where pop is high. Every instruction gives exactly one result.
// A decoder classifies each word into a two-entry queue; the back end reads
// the register file, executes and writes one result queue entry per cycle
// while the result queue has room. Items pass the input queue, the execute
// register and the result queue; loads also the load stage, as the data memory
// read is registered, and hold the next item in the back end until the load
// result is pushed. The start pc register is written with i_start_pc_we and
// loads the pc at once. After reset the register file and data memory are
// cleared, one memory row of four bytes per cycle, and full stays high until
// the last row is cleared. When the receiver stops popping, the result queue
// fills, the back end holds and full rises once the input queue is also full.
// MEM_BYTES must be a power of two.
module rv32i_instruction_execute import rvx_pkg::*; #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start_pc_we,
    input  logic [31:0] i_start_pc,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_instruction,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic        o_halted,
    output logic        o_illegal
);

    t_dec dec, q_head;
    t_res res, out_head;
    logic q_full, q_empty, q_pop, res_push, res_full, clearing;

    // Front: classify and queue
    rvx_decode u_decode (
        .i_instruction (i_instruction),
        .o_dec         (dec)
    );

    assign full = q_full || clearing;

    rvx_fifo #(.W($bits(t_dec)), .DEPTH(2)) u_dec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !clearing),
        .i_data  (dec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    // Back: execute
    rvx_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_start_pc_we),
        .i_cfg_pc   (i_start_pc),
        .i_q_empty  (q_empty),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res),
        .o_clearing (clearing)
    );

    // Result queue
    rvx_fifo #(.W($bits(t_res)), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_head)
    );

    assign o_next_pc     = out_head.next_pc;
    assign o_reg_written = out_head.reg_written;
    assign o_reg_index   = out_head.reg_index;
    assign o_reg_value   = out_head.reg_value;
    assign o_halted      = out_head.halted;
    assign o_illegal     = out_head.illegal;

endmodule

/* sim/tb_checker.sv */
// Checker for the RV32I execute block: predicts every result and compares it.
`timescale 1ns / 1ps

module tb_checker import rvx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start_pc_we,
    input  logic [31:0] i_start_pc,
    input  logic        push,
    input  logic        full,
    input  logic [31:0] i_instruction,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] i_next_pc,
    input  logic        i_reg_written,
    input  logic [4:0]  i_reg_index,
    input  logic [31:0] i_reg_value,
    input  logic        i_halted,
    input  logic        i_illegal,
    output int          o_pending,
    output int          o_errors,
    output int          o_results
);

    // Architectural state of the machine as the checker sees it.
    logic [31:0] regs [32];
    logic [31:0] pc_q;
    logic        stopped;
    logic [7:0]  dmem [65536];
    t_res        awaited [$];

    function automatic logic [31:0] load_bytes(logic [31:0] addr, int n);
        logic [31:0] v;
        logic [15:0] idx;
        v = '0;
        for (int i = 0; i < n; i++) begin
            idx = 16'(addr + i);
            v[8*i +: 8] = dmem[idx];
        end
        return v;
    endfunction

    function automatic void store_bytes(logic [31:0] addr, logic [31:0] v, int n);
        logic [15:0] idx;
        for (int i = 0; i < n; i++) begin
            idx = 16'(addr + i);
            dmem[idx] = v[8*i +: 8];
        end
    endfunction

    // Executes one instruction word on the checker state and returns its result.
    function automatic t_res execute_word(logic [31:0] w);
        t_res        r;
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a, b, immi, op2, val, npc, addr, imm, ld;
        logic [4:0]  sh;
        logic        wr, ill, take, isr;
        opc  = w[6:0];
        rd   = w[11:7];
        f3   = w[14:12];
        f7   = w[31:25];
        a    = regs[w[19:15]];
        b    = regs[w[24:20]];
        immi = {{20{w[31]}}, w[31:20]};
        npc  = pc_q + PC_STEP;
        wr   = 1'b0;
        ill  = 1'b0;
        val  = '0;
        r    = '0;
        if (stopped) begin
            r.next_pc = pc_q;
            r.halted  = 1'b1;
            return r;
        end
        case (opc)
            OP_REG, OP_IMM: begin
                isr = (opc == OP_REG);
                op2 = isr ? b : immi;
                sh  = op2[4:0];
                wr  = 1'b1;
                case (f3)
                    ALU_ADD: begin
                        if (!isr || f7 == F7_BASE) val = a + op2;
                        else if (f7 == F7_ALT) val = a - op2;
                        else wr = 1'b0;
                    end
                    ALU_SLL:  val = a << sh;
                    ALU_SLT:  val = ($signed(a) < $signed(op2)) ? 32'd1 : 32'd0;
                    ALU_SLTU: val = (a < op2) ? 32'd1 : 32'd0;
                    ALU_XOR:  val = a ^ op2;
                    ALU_SR: begin
                        if (f7 == F7_BASE) val = a >> sh;
                        else if (f7 == F7_ALT) val = $signed(a) >>> sh;
                        else wr = 1'b0;
                    end
                    ALU_OR:   val = a | op2;
                    default:  val = a & op2;
                endcase
            end
            OP_LUI: begin
                wr  = 1'b1;
                val = w & UPPER_MASK;
            end
            OP_AUIPC: begin
                wr  = 1'b1;
                val = pc_q + (w & UPPER_MASK);
            end
            OP_JAL: begin
                imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                wr  = 1'b1;
                val = pc_q + PC_STEP;
                npc = pc_q + imm;
            end
            OP_JALR: begin
                wr  = 1'b1;
                val = pc_q + PC_STEP;
                npc = (a + immi) & ~32'd1;
            end
            OP_BRANCH: begin
                imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    BR_EQ:   take = (a == b);
                    BR_NE:   take = (a != b);
                    BR_LT:   take = $signed(a) < $signed(b);
                    BR_GE:   take = !($signed(a) < $signed(b));
                    BR_LTU:  take = a < b;
                    BR_GEU:  take = a >= b;
                    default: take = 1'b0;
                endcase
                if (take) npc = pc_q + imm;
            end
            OP_LOAD: begin
                addr = a + immi;
                wr   = 1'b1;
                case (f3)
                    LD_B: begin
                        ld  = load_bytes(addr, 1);
                        val = {{24{ld[7]}}, ld[7:0]};
                    end
                    LD_H: begin
                        ld  = load_bytes(addr, 2);
                        val = {{16{ld[15]}}, ld[15:0]};
                    end
                    LD_W:    val = load_bytes(addr, 4);
                    LD_BU:   val = load_bytes(addr, 1);
                    LD_HU:   val = load_bytes(addr, 2);
                    default: wr = 1'b0;
                endcase
            end
            OP_STORE: begin
                addr = a + {{20{w[31]}}, f7, rd};
                if (f3 == ST_B) store_bytes(addr, b, 1);
                else if (f3 == ST_H) store_bytes(addr, b, 2);
                else if (f3 == ST_W) store_bytes(addr, b, 4);
            end
            OP_FENCE: ;
            OP_SYSTEM: begin
                if (w[31:20] == SYS_ECALL || w[31:20] == SYS_EBREAK) begin
                    stopped = 1'b1;
                    npc = pc_q;
                end else begin
                    ill = 1'b1;
                end
            end
            default: ill = 1'b1;
        endcase
        if (rd == 5'd0) wr = 1'b0;
        if (wr) regs[rd] = val;
        regs[0] = '0;
        pc_q = npc;
        r.next_pc     = npc;
        r.reg_written = wr;
        r.reg_index   = wr ? rd : 5'd0;
        r.reg_value   = wr ? val : 32'd0;
        r.halted      = stopped;
        r.illegal     = ill;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        o_errors++;
        $display("%0t: mismatch on %s at result %0d: got %h, expected %h",
                 $realtime, what, o_results, got, want);
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_pending = 0;
    end

    // Track configuration, accepted items and accepted results on each edge.
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            pc_q    = '0;
            stopped = 1'b0;
            awaited.delete();
        end else begin
            if (i_start_pc_we) pc_q = i_start_pc;
            if (push && !full) awaited.push_back(execute_word(i_instruction));
            if (pop && !empty) begin
                if (awaited.size() == 0) begin
                    o_errors++;
                    $display("%0t: result with no item waiting", $realtime);
                end else begin
                    want = awaited.pop_front();
                    if (i_next_pc !== want.next_pc)
                        report_mismatch("next_pc", i_next_pc, want.next_pc);
                    if (i_reg_written !== want.reg_written)
                        report_mismatch("reg_written", i_reg_written, want.reg_written);
                    if (i_reg_index !== want.reg_index)
                        report_mismatch("reg_index", i_reg_index, want.reg_index);
                    if (i_reg_value !== want.reg_value)
                        report_mismatch("reg_value", i_reg_value, want.reg_value);
                    if (i_halted !== want.halted)
                        report_mismatch("halted", i_halted, want.halted);
                    if (i_illegal !== want.illegal)
                        report_mismatch("illegal", i_illegal, want.illegal);
                end
                o_results++;
            end
        end
        o_pending = awaited.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top for the RV32I execute block: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_top import rvx_pkg::*;;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start_pc_we = 1'b0;
    logic [31:0] i_start_pc = '0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_instruction = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_next_pc;
    logic        o_reg_written;
    logic [4:0]  o_reg_index;
    logic [31:0] o_reg_value;
    logic        o_halted;
    logic        o_illegal;
    int          pending, errors, results;
    int          sent = 0;
    int          cycles = 0;
    int          phases = 0;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;

    localparam int CYCLE_LIMIT = 600000;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rv32i_instruction_execute u_top (
        .i_clk, .i_rst_n, .i_start_pc_we, .i_start_pc, .push, .full, .i_instruction,
        .empty, .pop, .o_next_pc, .o_reg_written, .o_reg_index, .o_reg_value,
        .o_halted, .o_illegal
    );

    tb_checker u_checker (
        .i_clk, .i_rst_n, .i_start_pc_we, .i_start_pc, .push, .full, .i_instruction,
        .empty, .pop, .i_next_pc(o_next_pc), .i_reg_written(o_reg_written),
        .i_reg_index(o_reg_index), .i_reg_value(o_reg_value), .i_halted(o_halted),
        .i_illegal(o_illegal), .o_pending(pending), .o_errors(errors), .o_results(results)
    );

    // Instruction encoders.
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // Base register: x0 at least half the time so loads and stores meet in a small window.
    function automatic logic [4:0] pick_base();
        return ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
    endfunction

    // Random instruction of a random class; never ECALL or EBREAK.
    function automatic logic [31:0] random_word();
        int          k;
        logic [31:0] w;
        logic [6:0]  f7;
        k = $urandom_range(0, 99);
        w = $urandom();
        f7 = ($urandom_range(0, 3) == 0) ? w[31:25] : (w[30] ? F7_ALT : F7_BASE);
        if (k < 20) return {w[31:7], OP_IMM};
        if (k < 25) return {f7, w[24:12], w[11:7], OP_IMM} & 32'hFFFF_FFFF;
        if (k < 40) return {f7, w[24:7], OP_REG};
        if (k < 45) return {w[31:7], OP_LUI};
        if (k < 50) return {w[31:7], OP_AUIPC};
        if (k < 62) return {w[31:7], OP_BRANCH};
        if (k < 66) return {w[31:7], OP_JAL};
        if (k < 70) return {w[31:15], 3'd0, w[11:7], OP_JALR};
        if (k < 82) return enc_i(w[31:20], pick_base(), w[14:12], w[11:7], OP_LOAD);
        if (k < 94) return enc_s(w[31:20], w[24:20], pick_base(), w[14:12]);
        if (k < 96) return {w[31:7], OP_FENCE};
        if (k < 98) begin
            if (w[31:21] == '0) w[31] = 1'b1;
            return {w[31:7], OP_SYSTEM};
        end
        if (w[6:0] == OP_SYSTEM && w[31:21] == '0) w[31] = 1'b1;
        return w;
    endfunction

    // Offers one item and holds it until the block takes it.
    task automatic send(logic [31:0] w);
        i_instruction <= w;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_start_pc(logic [31:0] v);
        i_start_pc <= v;
        i_start_pc_we <= 1'b1;
        @(posedge i_clk);
        i_start_pc_we <= 1'b0;
        phases++;
    endtask

    // Receiver pacing: random stall bursts, plus one long hold on request.
    initial begin
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus: directed items, random phases under several start pcs, then halt.
    initial begin
        logic [31:0] starts [4];
        starts = '{32'h0000_0000, 32'hFFFF_FFF0, 32'h8000_0000, $urandom()};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        set_start_pc(32'hFFFF_FFFC);

        // Register setup and ALU extremes.
        send(enc_i(12'hFFF, 5'd0, ALU_ADD, 5'd1, OP_IMM));
        send(enc_i(12'h7FF, 5'd0, ALU_ADD, 5'd2, OP_IMM));
        send({20'h80000, 5'd3, OP_LUI});
        send({20'hFFFFF, 5'd4, OP_AUIPC});
        for (int f = 0; f < 8; f++)
            send(enc_r((f == 0 || f == 5) ? F7_ALT : F7_BASE, 5'd3, 5'd1, 3'(f),
                       5'(8 + f), OP_REG));
        send(enc_r(7'h01, 5'd2, 5'd1, ALU_ADD, 5'd16, OP_REG));
        send(enc_i({F7_ALT, 5'd31}, 5'd3, ALU_SR, 5'd17, OP_IMM));
        send(enc_i({7'h10, 5'd1}, 5'd3, ALU_SR, 5'd18, OP_IMM));
        send(enc_i(12'd5, 5'd1, ALU_ADD, 5'd0, OP_IMM));
        // Memory across the wrap boundary, misaligned, and undefined widths.
        send(enc_s(12'hFFF, 5'd3, 5'd0, ST_W));
        send(enc_s(12'h001, 5'd1, 5'd0, ST_H));
        send(enc_s(12'h002, 5'd2, 5'd0, 3'd5));
        for (int f = 0; f < 8; f++)
            send(enc_i(12'hFFF, 5'd0, 3'(f), 5'(20 + f), OP_LOAD));
        // Branches of every kind, jumps, fence, illegal words.
        for (int f = 0; f < 8; f++)
            send(enc_b(13'h1FF8, 5'd3, 5'd1, 3'(f)));
        send(enc_j(21'h100004, 5'd29));
        send(enc_j(21'h0FFFFE, 5'd0));
        send(enc_i(12'h7FF, 5'd1, 3'd0, 5'd30, OP_JALR));
        send({25'h0, OP_FENCE});
        send(32'hFFFF_FFFF);
        send(enc_i(12'h002, 5'd0, 3'd0, 5'd0, OP_SYSTEM));
        drain();

        // Random phases; the first starts with a long receiver hold.
        foreach (starts[p]) begin
            set_start_pc(starts[p]);
            if (p == 0) hold_req = 1'b1;
            if (p == 3) calm = 1'b1;
            for (int n = 0; n < 190; n++) send(random_word());
            drain();
        end

        // Halt, then items that must be ignored.
        send(enc_i(SYS_EBREAK, 5'd0, 3'd0, 5'd0, OP_SYSTEM));
        for (int n = 0; n < 4; n++) send(random_word());
        send(enc_i(SYS_ECALL, 5'd0, 3'd0, 5'd0, OP_SYSTEM));
        drain();
        repeat (20) @(posedge i_clk);

        $display("Ran %0d instructions over %0d start pc settings, %0d results checked.",
                 sent, phases, results);
        $display("Covered ALU, memory, branch, jump, illegal and halt behavior.");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
design/rvx_pkg.sv
design/rvx_ram.sv
design/rvx_fifo.sv
design/rvx_decode.sv
design/rvx_back.sv
design/rv32i_instruction_execute.sv
sim/tb_checker.sv
sim/tb_top.sv
